/* design/deq_pkg.sv */
package deq_pkg;

   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int FILL_W = 5;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } deq_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 2'd0,
      ST_EMPTY_POP = 2'd1,
      ST_FULL_PUSH = 2'd2
   } deq_status_type;

   typedef struct packed {
      logic               valid;
      logic signed [WORD_W-1:0] data;
   } deq_link_type;

   typedef struct packed {
      logic               en;
      deq_kind_type       kind;
      logic signed [WORD_W-1:0] value;
   } deq_ctrl_type;

endpackage

/* design/deq_if.sv */
interface deq_req_if import deq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] front_word;
   logic signed [WORD_W-1:0] back_word;
   logic [FILL_W-1:0]        fill;
   logic [STAT_W-1:0]        status;

   modport source (output valid, output front_word, output back_word, output fill,
                   output status, input ready);
   modport sink   (input valid, input front_word, input back_word, input fill,
                   input status, output ready);
endinterface

/* design/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words held in a row of DEPTH cells, the front
// word always in the first cell; pushes and pops at the front shift the whole row by one
// place, while a push or pop at the back touches only the cell at the end of the occupied run.
// One item is accepted per cycle; the cells and a pending flag register it, and its result beat
// is then registered on the result channel, because the result is read from the updated cells,
// including the OR-reduction over all DEPTH cells that picks out the back word. Acceptance
// stalls only while a finished beat waits and another result is ready to replace it. A pop on
// an empty queue and a push on a full one leave the contents untouched and are reported in the
// status field; an empty queue shows all ones in both word fields.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   deq_req_if.sink   req_bus,
   deq_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(DEPTH + 1);

   deq_link_type own   [DEPTH];
   deq_link_type lft   [DEPTH];
   deq_link_type rgt   [DEPTH];
   deq_ctrl_type ctrl;

   logic [CW-1:0]  count_ff, count_in;
   logic           pend_ff, pend_in;
   deq_status_type pstat_ff, pstat_in;

   logic                     rvalid_ff, rvalid_in;
   logic signed [WORD_W-1:0] rfront_ff, rfront_in;
   logic signed [WORD_W-1:0] rback_ff, rback_in;
   logic [FILL_W-1:0]        rfill_ff, rfill_in;
   deq_status_type           rstat_ff, rstat_in;

   logic                     acc, cap, empty, full, is_push;
   deq_kind_type             kind;
   logic signed [WORD_W-1:0] back_or;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign lft[g] = '{valid: 1'b1, data: req_bus.value};
         end else begin : g_mid
            assign lft[g] = own[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign rgt[g] = '{valid: 1'b0, data: '0};
         end else begin : g_inner
            assign rgt[g] = own[g+1];
         end
         deq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (lft[g]),
            .right (rgt[g]),
            .own   (own[g])
         );
      end
   endgenerate

   assign kind    = deq_kind_type'(req_bus.kind);
   assign empty   = !own[0].valid;
   assign full    = own[DEPTH-1].valid;
   assign is_push = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);

   assign req_bus.ready = !(pend_ff && rvalid_ff && !rsp_bus.ready);
   assign acc           = req_bus.valid && req_bus.ready;
   assign cap           = pend_ff && (!rvalid_ff || rsp_bus.ready);

   always_comb begin
      if (is_push && full) begin
         pstat_in = ST_FULL_PUSH;
      end else if (!is_push && empty) begin
         pstat_in = ST_EMPTY_POP;
      end else begin
         pstat_in = ST_DONE;
      end
   end

   assign ctrl.en    = acc && (pstat_in == ST_DONE);
   assign ctrl.kind  = kind;
   assign ctrl.value = req_bus.value;

   always_comb begin
      count_in = count_ff;
      if (ctrl.en) begin
         if (is_push) begin
            count_in = count_ff + CW'(1);
         end else begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (acc) begin
         pend_in = 1'b1;
      end else if (cap) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      back_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (own[i].valid && !rgt[i].valid) begin
            back_or = back_or | own[i].data;
         end
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      rfront_in = rfront_ff;
      rback_in  = rback_ff;
      rfill_in  = rfill_ff;
      rstat_in  = rstat_ff;
      if (cap) begin
         rvalid_in = 1'b1;
         rfront_in = own[0].valid ? own[0].data : '1;
         rback_in  = own[0].valid ? back_or : '1;
         rfill_in  = FILL_W'(count_ff);
         rstat_in  = pstat_ff;
      end else if (rsp_bus.ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         pstat_ff <= pstat_in;
      end
      rfront_ff <= rfront_in;
      rback_ff  <= rback_in;
      rfill_ff  <= rfill_in;
      rstat_ff  <= rstat_in;
   end

   assign rsp_bus.valid      = rvalid_ff;
   assign rsp_bus.front_word = rfront_ff;
   assign rsp_bus.back_word  = rback_ff;
   assign rsp_bus.fill       = rfill_ff;
   assign rsp_bus.status     = rstat_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds depth");

   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == !own[0].valid)
      else $error("first cell occupancy disagrees with fill count");

   a_full_match: assert property (@(posedge clock) disable iff (reset)
      own[DEPTH-1].valid |-> (count_ff == CW'(DEPTH)))
      else $error("last cell occupied while fill count is below depth");

   a_no_lost_beat: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !cap) |=> (pend_ff && $stable(count_ff)))
      else $error("pending beat lost or cells changed while it waited");
`endif

endmodule

/* design/deq_cell.sv */
module deq_cell import deq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  deq_ctrl_type ctrl,
   input  deq_link_type left,
   input  deq_link_type right,
   output deq_link_type own
);

   logic                     valid_ff, valid_in;
   logic signed [WORD_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.en) begin
         case (ctrl.kind)
            KIND_PUSH_FRONT: begin
               valid_in = left.valid;
               data_in  = left.data;
            end
            KIND_PUSH_BACK: begin
               if (!valid_ff && left.valid) begin
                  valid_in = 1'b1;
                  data_in  = ctrl.value;
               end
            end
            KIND_POP_FRONT: begin
               valid_in = right.valid;
               data_in  = right.data;
            end
            KIND_POP_BACK: begin
               if (valid_ff && !right.valid) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign own.valid = valid_ff;
   assign own.data  = data_ff;

endmodule

/* bench/double_ended_queue_test.sv */
module double_ended_queue_test;
   import deq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 64;
   localparam int PHASE_ITEMS = 360;

   typedef struct packed {
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] back_word;
      logic [FILL_W-1:0]        fill;
      deq_status_type           status;
   } deq_view_type;

   typedef struct packed {
      deq_kind_type             kind;
      logic signed [WORD_W-1:0] value;
      logic [4:0]               reps;
      logic                     typed;
      deq_view_type             want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue #(.DEPTH(DEPTH)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted contents of the deque, kept as a ring with its own head and count.
   logic signed [WORD_W-1:0] ring_words [DEPTH];
   logic [3:0]               ring_head = '0;
   int                       ring_count = 0;

   deq_view_type awaited_views [$];
   plan_row_type plan [15];

   int mismatches    = 0;
   int beats_checked = 0;
   int push_count    = 0;
   int pop_count     = 0;
   int drop_count    = 0;
   int empty_count   = 0;
   int fill_peak     = 0;
   int holds_done    = 0;
   int hold_requests = 0;
   int stall_cycles  = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;

   function automatic deq_view_type deque_apply(deq_kind_type kind,
                                                logic signed [WORD_W-1:0] value);
      deq_view_type view;
      logic [3:0]   slot;
      view.status = ST_DONE;
      if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
         if (ring_count >= DEPTH) begin
            view.status = ST_FULL_PUSH;
            drop_count++;
         end else if (kind == KIND_PUSH_FRONT) begin
            ring_head = ring_head - 4'd1;
            ring_words[ring_head] = value;
            ring_count++;
            push_count++;
         end else begin
            slot = ring_head + 4'(ring_count);
            ring_words[slot] = value;
            ring_count++;
            push_count++;
         end
      end else begin
         if (ring_count == 0) begin
            view.status = ST_EMPTY_POP;
            empty_count++;
         end else begin
            if (kind == KIND_POP_FRONT) ring_head = ring_head + 4'd1;
            ring_count--;
            pop_count++;
         end
      end
      if (ring_count > fill_peak) fill_peak = ring_count;
      view.fill = FILL_W'(ring_count);
      if (ring_count != 0) begin
         slot = ring_head + 4'(ring_count - 1);
         view.front_word = ring_words[ring_head];
         view.back_word  = ring_words[slot];
      end else begin
         view.front_word = '1;
         view.back_word  = '1;
      end
      return view;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result beat %0d: %s", beats_checked, msg);
      mismatches++;
   endtask

   task automatic send_beat(input deq_kind_type kind, input logic signed [WORD_W-1:0] value,
                            input logic typed, input deq_view_type want);
      int           gap;
      deq_view_type view;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      view = deque_apply(kind, value);
      awaited_views.insert(awaited_views.size(), typed ? want : view);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_views.size() != 0);
   endtask

   always @(posedge clock) begin
      deq_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (awaited_views.size() == 0) begin
            report_mismatch("result beat with nothing awaited");
         end else begin
            want = awaited_views[0];
            awaited_views.delete(0);
            if (rsp_bus.front_word !== want.front_word)
               report_mismatch($sformatf("front_word %h, expected %h",
                                         rsp_bus.front_word, want.front_word));
            if (rsp_bus.back_word !== want.back_word)
               report_mismatch($sformatf("back_word %h, expected %h",
                                         rsp_bus.back_word, want.back_word));
            if (rsp_bus.fill !== want.fill)
               report_mismatch($sformatf("fill %0d, expected %0d", rsp_bus.fill, want.fill));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("[double_ended_queue] ERROR");
            $finish;
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   initial begin
      int                       phase;
      int                       n;
      int                       push_pct;
      deq_kind_type             kind;
      logic signed [WORD_W-1:0] value;

      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_PUSH_FRONT;
      req_bus.value = '0;

      plan = '{
         '{KIND_POP_FRONT,  32'h00000000, 5'd1, 1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  ST_EMPTY_POP}},
         '{KIND_POP_BACK,   32'h12345678, 5'd1, 1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  ST_EMPTY_POP}},
         '{KIND_PUSH_FRONT, 32'h7FFFFFFF, 5'd1, 1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, 5'd1,  ST_DONE}},
         '{KIND_PUSH_BACK,  32'h80000000, 5'd1, 1'b1, '{32'h7FFFFFFF, 32'h80000000, 5'd2,  ST_DONE}},
         '{KIND_POP_FRONT,  32'h00000000, 5'd1, 1'b1, '{32'h80000000, 32'h80000000, 5'd1,  ST_DONE}},
         '{KIND_POP_BACK,   32'hFFFFFFFF, 5'd1, 1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  ST_DONE}},
         '{KIND_PUSH_BACK,  32'hFFFFFFFF, 5'd1, 1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd1,  ST_DONE}},
         '{KIND_PUSH_FRONT, 32'h00000000, 5'd1, 1'b1, '{32'h00000000, 32'hFFFFFFFF, 5'd2,  ST_DONE}},
         '{KIND_PUSH_FRONT, 32'h55555555, 5'd7, 1'b0, '0},
         '{KIND_PUSH_BACK,  32'hAAAAAAAA, 5'd7, 1'b0, '0},
         '{KIND_PUSH_FRONT, 32'h00000001, 5'd1, 1'b1, '{32'h5555555B, 32'hAAAAAAB0, 5'd16, ST_FULL_PUSH}},
         '{KIND_PUSH_BACK,  32'h00000002, 5'd1, 1'b1, '{32'h5555555B, 32'hAAAAAAB0, 5'd16, ST_FULL_PUSH}},
         '{KIND_POP_FRONT,  32'h00000000, 5'd8, 1'b0, '0},
         '{KIND_POP_BACK,   32'h00000000, 5'd8, 1'b0, '0},
         '{KIND_POP_FRONT,  32'h00000000, 5'd1, 1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  ST_EMPTY_POP}}
      };

      send_idle_pct = 23;
      rcv_idle_pct  = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (int i = 0; i < plan[r].reps; i++)
            send_beat(plan[r].kind, plan[r].value + i, plan[r].typed, plan[r].want);
      end

      // Runs of push-heavy, balanced and pop-heavy beats drive the deque between empty and full.
      push_pct = 50;
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
         rcv_idle_pct  = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 30 == 0) begin
               case ($urandom_range(2))
                  0: push_pct = 15;
                  1: push_pct = 50;
                  default: push_pct = 85;
               endcase
            end
            if (n == 120) hold_requests++;
            if (n == 240) drain_results();
            if ($urandom_range(99) < push_pct)
               kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            else
               kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
            case ($urandom_range(15))
               0: value = 32'h7FFFFFFF;
               1: value = 32'h80000000;
               2: value = '0;
               3: value = '1;
               default: value = $urandom;
            endcase
            send_beat(kind, value, 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("%0d pushes, %0d pops, %0d pushes dropped at full, %0d pops on empty",
               push_count, pop_count, drop_count, empty_count);
      $display("%0d result beats checked, fill peaked at %0d, %0d receiver hold-offs",
               beats_checked, fill_peak, holds_done);
      if (mismatches == 0) begin
         $display("[double_ended_queue] OK");
      end else begin
         $display("[double_ended_queue] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
design/deq_pkg.sv
design/deq_if.sv
design/deq_cell.sv
design/double_ended_queue.sv
bench/double_ended_queue_test.sv
